// ----- rtl/rtd_pkg.sv -----
// ----------------------------------------------------------------------------
// RTD linearizer package
// Shared widths, field layout of the channel settings word and curve constants.
// ----------------------------------------------------------------------------
package rtd_pkg;

   localparam int SetWidth = 43;
   localparam int DivBits  = 32;

   // sensor type field: bit 2 marks a 50-ohm sensor, bits 1:0 pick the curve
   localparam logic [1:0] CurvePt3910 = 2'd0;
   localparam logic [1:0] CurveCu4280 = 2'd1;
   localparam logic [1:0] CurvePt3850 = 2'd2;
   localparam logic [1:0] CurveCu4260 = 2'd3;

   localparam logic [1:0] RegChan0 = 2'd0;
   localparam logic [1:0] RegChan1 = 2'd1;

   localparam logic [SetWidth-1:0] SetReset = SetWidth'(32768);

   localparam logic [31:0] PtaMul  = 32'd29153;
   localparam logic [31:0] PtaAdd1 = 32'd2206179461;
   localparam logic [31:0] PtaAdd2 = 32'd630046652;
   localparam logic [31:0] PtaAdd3 = 32'd197216040;
   localparam logic [31:0] PtbMul  = 32'd57080;
   localparam logic [31:0] PtbAdd1 = 32'd902791633;
   localparam logic [31:0] PtbAdd2 = 32'd653227277;
   localparam logic [31:0] PtbAdd3 = 32'd161076900;
   localparam logic [31:0] CuaHiMul = 32'd76599;
   localparam logic [15:0] CuaHiAdd = 16'd3939;
   localparam logic [31:0] CuaLoMul = 32'd1815;
   localparam logic [31:0] CuaLoAdd1 = 32'd36033;
   localparam logic [15:0] CuaLoAdd2 = 16'd4647;
   localparam logic [15:0] CuaHiMin = 16'd38289;
   localparam logic [15:0] CuaLoMax = 16'd38285;
   localparam logic [15:0] CuaGap  = 16'd26315;
   localparam logic [31:0] CubMul  = 32'd38446;
   localparam logic [15:0] CubAdd  = 16'd3850;

   typedef struct packed {
      logic [7:0] offs;
      logic [2:0] kind;
   } side_type;

endpackage

// ----- rtl/rtd_div.sv -----
// ----------------------------------------------------------------------------
// RTD pipelined divider
// Restoring divider, one quotient bit per register stage. A zero divisor
// yields an all-ones quotient.
// ----------------------------------------------------------------------------
module rtd_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [31:0]               dividend,
   input  logic [15:0]               divisor,
   input  rtd_pkg::side_type         in_side,
   output logic                      out_valid,
   output logic [31:0]               quotient,
   output rtd_pkg::side_type         out_side
);

   logic [rtd_pkg::DivBits-1:0] valid_ff;
   logic [15:0]                 rem_ff  [rtd_pkg::DivBits];
   logic [31:0]                 quo_ff  [rtd_pkg::DivBits];
   logic [31:0]                 dvd_ff  [rtd_pkg::DivBits];
   logic [15:0]                 gain_ff [rtd_pkg::DivBits];
   rtd_pkg::side_type           side_ff [rtd_pkg::DivBits];

   for (genvar i = 0; i < rtd_pkg::DivBits; i++) begin : g_stage
      logic              valid_src;
      logic [15:0]       rem_src;
      logic [31:0]       quo_src;
      logic [31:0]       dvd_src;
      logic [15:0]       gain_src;
      rtd_pkg::side_type side_src;
      logic [16:0]       trial;
      logic              fits;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign quo_src   = '0;
         assign dvd_src   = dividend;
         assign gain_src  = divisor;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign quo_src   = quo_ff[i-1];
         assign dvd_src   = dvd_ff[i-1];
         assign gain_src  = gain_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      assign trial = {rem_src, dvd_src[31]};
      assign fits  = trial >= {1'b0, gain_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= fits ? 16'(trial - {1'b0, gain_src}) : trial[15:0];
            quo_ff[i]  <= {quo_src[30:0], fits};
            dvd_ff[i]  <= {dvd_src[30:0], 1'b0};
            gain_ff[i] <= gain_src;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[rtd_pkg::DivBits-1];
   assign quotient  = quo_ff[rtd_pkg::DivBits-1];
   assign out_side  = side_ff[rtd_pkg::DivBits-1];

endmodule

// ----- rtl/rtd_curve.sv -----
// ----------------------------------------------------------------------------
// RTD curve evaluator
// Adds the offset, applies 50-ohm doubling and evaluates all four
// linearization curves in a five-stage pipeline, then picks one.
// ----------------------------------------------------------------------------
module rtd_curve (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [15:0]       quo,
   input  rtd_pkg::side_type in_side,
   output logic              out_valid,
   output logic [15:0]       res_out,
   output logic [15:0]       temp_out
);

   logic [4:0] valid_ff;

   // stage 0
   logic [15:0] res0_ff, r0_ff;
   logic        bad0_ff;
   logic [2:0]  kind0_ff;
   logic [15:0] res0_in, r0_in;

   // stage 1
   logic [15:0] res1_ff, r1_ff;
   logic        bad1_ff;
   logic [2:0]  kind1_ff;
   logic [31:0] pta1_ff, ptb1_ff, cuahi1_ff, cualo1_ff, cub1_ff;

   // stage 2
   logic [15:0] res2_ff, r2_ff;
   logic        bad2_ff;
   logic [2:0]  kind2_ff;
   logic [31:0] pta2_ff, ptb2_ff, cualo2_ff;
   logic [15:0] cuahi2_ff, cub2_ff;
   logic [31:0] pta2_v, ptb2_v, cualo2_v;

   // stage 3
   logic [15:0] res3_ff;
   logic        bad3_ff;
   logic [2:0]  kind3_ff;
   logic [31:0] pta3_ff, ptb3_ff;
   logic [15:0] cua3_ff, cub3_ff;
   logic [31:0] pta3_v, ptb3_v;
   logic [15:0] cua3_in;

   // stage 4
   logic [15:0] res4_ff, temp4_ff;
   logic [15:0] temp4_in;
   logic [31:0] pta4_v, ptb4_v;

   assign res0_in = 16'(quo + {{8{in_side.offs[7]}}, in_side.offs});
   assign r0_in   = in_side.kind[2] ? {res0_in[14:0], 1'b0} : res0_in;

   assign pta2_v   = ((pta1_ff >> 3) + rtd_pkg::PtaAdd1) >> 16;
   assign ptb2_v   = ((ptb1_ff >> 2) + rtd_pkg::PtbAdd1) >> 16;
   assign cualo2_v = (cualo1_ff >> 16) + rtd_pkg::CuaLoAdd1;

   assign pta3_v = ((pta2_ff >> 6) + rtd_pkg::PtaAdd2) >> 14;
   assign ptb3_v = ((ptb2_ff >> 6) + rtd_pkg::PtbAdd2) >> 14;

   always_comb begin
      if (r2_ff >= rtd_pkg::CuaHiMin) begin
         cua3_in = cuahi2_ff;
      end else if (r2_ff < rtd_pkg::CuaLoMax) begin
         cua3_in = 16'(cualo2_ff[31:16] + rtd_pkg::CuaLoAdd2);
      end else begin
         cua3_in = rtd_pkg::CuaGap;
      end
   end

   assign pta4_v = (pta3_ff + rtd_pkg::PtaAdd3) >> 16;
   assign ptb4_v = (ptb3_ff + rtd_pkg::PtbAdd3) >> 16;

   always_comb begin
      case (kind3_ff[1:0])
         rtd_pkg::CurvePt3910: temp4_in = pta4_v[15:0];
         rtd_pkg::CurveCu4280: temp4_in = cua3_ff;
         rtd_pkg::CurvePt3850: temp4_in = ptb4_v[15:0];
         default:              temp4_in = cub3_ff;
      endcase
      if (bad3_ff) begin
         temp4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res0_ff  <= res0_in;
         r0_ff    <= r0_in;
         bad0_ff  <= in_side.kind[2] & res0_in[15];
         kind0_ff <= in_side.kind;

         res1_ff   <= res0_ff;
         r1_ff     <= r0_ff;
         bad1_ff   <= bad0_ff;
         kind1_ff  <= kind0_ff;
         pta1_ff   <= 32'({16'b0, r0_ff} * rtd_pkg::PtaMul);
         ptb1_ff   <= 32'({16'b0, r0_ff} * rtd_pkg::PtbMul);
         cuahi1_ff <= 32'({16'b0, r0_ff} * rtd_pkg::CuaHiMul);
         cualo1_ff <= 32'({16'b0, r0_ff} * rtd_pkg::CuaLoMul);
         cub1_ff   <= 32'({16'b0, r0_ff} * rtd_pkg::CubMul);

         res2_ff   <= res1_ff;
         r2_ff     <= r1_ff;
         bad2_ff   <= bad1_ff;
         kind2_ff  <= kind1_ff;
         pta2_ff   <= 32'(pta2_v * {16'b0, r1_ff});
         ptb2_ff   <= 32'(ptb2_v * {16'b0, r1_ff});
         cualo2_ff <= 32'(cualo2_v * {16'b0, r1_ff});
         cuahi2_ff <= 16'({1'b0, cuahi1_ff[31:17]} + rtd_pkg::CuaHiAdd);
         cub2_ff   <= 16'(cub1_ff[31:16] + rtd_pkg::CubAdd);

         res3_ff  <= res2_ff;
         bad3_ff  <= bad2_ff;
         kind3_ff <= kind2_ff;
         pta3_ff  <= 32'(pta3_v * {16'b0, r2_ff});
         ptb3_ff  <= 32'(ptb3_v * {16'b0, r2_ff});
         cua3_ff  <= cua3_in;
         cub3_ff  <= cub2_ff;

         res4_ff  <= res3_ff;
         temp4_ff <= temp4_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign res_out   = res4_ff;
   assign temp_out  = temp4_ff;

endmodule

// ----- rtl/rtd_resistance_to_temperature.sv -----
// ----------------------------------------------------------------------------
// RTD resistance to temperature
// Converts an averaged converter code into sensor resistance and temperature
// in hundredths of kelvin (0 flags an error).
//
//   Channel  Direction  Contents
//   req_     in         tdata {double_delta_t, average_code}, tuser {warm_side, channel}
//   rsp_     out        tdata {temperature_code, resistance_code}
//   csr_     in         write-only channel settings words, index 0 and 1
//
// One transaction per cycle unless the output stalls; the path has two correction stages,
// 32 divider stages (one quotient bit each) and five curve stages.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits and loads 32768 into both settings words.
// ----------------------------------------------------------------------------
module rtd_resistance_to_temperature (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // average_code, double_delta_t
   input  logic [1:0]  req_tuser,   // channel, warm_side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // resistance_code, temperature_code
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [rtd_pkg::SetWidth-1:0] csr_wr_data
);

   logic [rtd_pkg::SetWidth-1:0] chan0_ff, chan1_ff, set_sel;
   logic en;

   logic              s1_valid_ff, s2_valid_ff;
   logic [15:0]       q1_ff, code1_ff, gain1_ff, gain2_ff, corr2_ff;
   logic signed [7:0] k1_ff;
   rtd_pkg::side_type side1_ff, side2_ff, side1_in;
   logic signed [24:0] prod2_v;

   logic              div_valid;
   logic [31:0]       div_quo;
   rtd_pkg::side_type div_side;
   logic [15:0]       res_out, temp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan0_ff <= rtd_pkg::SetReset;
         chan1_ff <= rtd_pkg::SetReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rtd_pkg::RegChan0: chan0_ff <= csr_wr_data;
            rtd_pkg::RegChan1: chan1_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign set_sel    = req_tuser[0] ? chan1_ff : chan0_ff;
   assign side1_in   = '{offs: set_sel[23:16], kind: set_sel[42:40]};

   // floor of q*k/64 via arithmetic shift
   assign prod2_v = $signed({1'b0, q1_ff}) * k1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff    <= 16'(({16'b0, req_tdata[15:0]} * {16'b0, req_tdata[31:16]}) >> 16);
         code1_ff <= req_tdata[15:0];
         k1_ff    <= req_tuser[1] ? set_sel[31:24] : set_sel[39:32];
         gain1_ff <= set_sel[15:0];
         side1_ff <= side1_in;

         corr2_ff <= 16'(code1_ff + prod2_v[21:6]);
         gain2_ff <= gain1_ff;
         side2_ff <= side1_ff;
      end
   end

   rtd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .dividend  ({corr2_ff, 16'b0}),
      .divisor   (gain2_ff),
      .in_side   (side2_ff),
      .out_valid (div_valid),
      .quotient  (div_quo),
      .out_side  (div_side)
   );

   rtd_curve u_curve (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .quo       (div_quo[15:0]),
      .in_side   (div_side),
      .out_valid (rsp_tvalid),
      .res_out   (res_out),
      .temp_out  (temp_out)
   );

   assign rsp_tdata = {temp_out, res_out};

endmodule
